/* src/assert_macros.svh */
// Assertion macros shared by the controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* src/pid_pkg.sv */
// Package with the item types, register indexes and fixed widths of the PID controller.
`timescale 1ns / 1ps
package pid_pkg;

  localparam int ERROR_WIDTH = 16;
  localparam int TICK_WIDTH  = 16;
  localparam int GAIN_WIDTH  = 16;
  localparam int DRIVE_WIDTH = 32;
  localparam int DIGIT_WIDTH = 16;

  localparam logic [1:0] CFG_PROPORTIONAL = 2'd0;
  localparam logic [1:0] CFG_INTEGRAL     = 2'd1;
  localparam logic [1:0] CFG_DERIVATIVE   = 2'd2;

  localparam logic signed [GAIN_WIDTH-1:0] GAIN_RESET = 16'sd256;

  typedef struct packed {
    logic signed [ERROR_WIDTH-1:0] error_value;
    logic [TICK_WIDTH-1:0]         elapsed_ticks;
  } in_item_t;

  typedef struct packed {
    logic signed [DRIVE_WIDTH-1:0] drive;
    logic                          rejected;
  } out_item_t;

endpackage

/* src/pid_div.sv */
// Radix-2 restoring divider for unsigned operands, one quotient bit per cycle.
`timescale 1ns / 1ps
module pid_div #(
  parameter int NUM_WIDTH = 24,
  parameter int DEN_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [NUM_WIDTH-1:0] dividend,
  input  logic [DEN_WIDTH-1:0] divisor,
  output logic                 busy,
  output logic [NUM_WIDTH-1:0] quotient
);

  localparam int CW = $clog2(NUM_WIDTH);

  logic [CW-1:0]        cnt;
  logic [DEN_WIDTH-1:0] rem;
  logic [DEN_WIDTH-1:0] dvs;
  logic [NUM_WIDTH-1:0] quo;
  logic [DEN_WIDTH:0]   rem_sh;
  logic [DEN_WIDTH:0]   rem_diff;
  logic                 ge;

  assign rem_sh   = {rem, quo[NUM_WIDTH-1]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign rem_diff = rem_sh - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      rem  <= '0;
      dvs  <= divisor;
      quo  <= dividend;
    end else if (busy) begin
      rem <= ge ? rem_diff[DEN_WIDTH-1:0] : rem_sh[DEN_WIDTH-1:0];
      quo <= {quo[NUM_WIDTH-2:0], ge};
      cnt <= cnt + 1'b1;
      if (cnt == CW'(NUM_WIDTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

/* src/pid_controller_step.sv */
// Top level of the fixed-point PID controller that turns one error item into one drive item.
//
// Input channel in_valid/in_stall/in_item carries an error and the ticks since the last
// step; output channel out_valid/out_stall/out_item returns the drive and a rejected flag.
// An item moves on a channel at a clock edge with valid high and stall low.
// Gains are written on cfg_valid/cfg_ready with cfg_index 0, 1, 2 for the proportional,
// integral and derivative gain; cfg_ready is always high and other indexes are ignored.
// An item with zero ticks raises out_valid with the held drive and the rejected flag set.
// For any other item the serial divider for the derivative gives one quotient bit per
// cycle, and then the derivative gain products are formed on the shared 17x17 multiplier
// and the result is registered. The proportional and integral products use the same
// multiplier while the divider runs. One item is processed at a time; in_stall is high
// from acceptance until its result enters the output register.
// The output register holds a finished result while out_stall is high; the next item
// may be accepted and worked on meanwhile, and waits for the register to free.
// Synchronous reset sets all gains to 256 (1.0 at the default 8 fraction bits), clears the
// integral, previous error and held drive, and empties the output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pid_controller_step #(
  parameter int GAIN_FRAC_BITS = 8,
  parameter int INTEGRAL_WIDTH = 48
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  pid_pkg::in_item_t in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output pid_pkg::out_item_t out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  localparam int F    = GAIN_FRAC_BITS;
  localparam int IW   = INTEGRAL_WIDTH;
  localparam int EW   = pid_pkg::ERROR_WIDTH;
  localparam int DGT  = pid_pkg::DIGIT_WIDTH;
  localparam int NW   = EW + F;
  localparam int DW   = NW + 1;
  localparam int OPW  = (IW > DW) ? IW : DW;
  localparam int NDM  = (OPW + DGT - 1) / DGT;
  localparam int BW   = NDM * DGT;
  localparam int NDI  = (IW + DGT - 1) / DGT;
  localparam int NDD  = (DW + DGT - 1) / DGT;
  localparam int DGW  = $clog2(NDM);
  localparam int AW   = IW + 2 * F + 17;
  localparam int SW   = AW - 2 * F;
  localparam int SHW  = $clog2(DGT * NDM + F + 1);
  localparam int PW   = 2 * (DGT + 1);
  localparam int SUMW = ((IW > 33) ? IW : 33) + 1;
  localparam int OW   = pid_pkg::DRIVE_WIDTH;

  typedef enum logic [3:0] {
    IDLE, MUL_ET, SAT_I, MUL_P, MUL_I, WAIT_DIV, MUL_D, DRAIN, FINISH, EMIT
  } state_t;

  state_t state;

  logic signed [15:0]    kp, ki, kd;
  logic signed [IW-1:0]  integral_sum;
  logic signed [EW-1:0]  previous_error;
  logic signed [OW-1:0]  held_drive;

  logic signed [EW-1:0]  e_q;
  logic [15:0]           t_q;
  logic                  d_neg;
  logic [BW-1:0]         mul_b;
  logic [DGW-1:0]        dig;
  logic signed [PW-1:0]  prod;
  logic [SHW-1:0]        prod_sh;
  logic                  prod_acc;
  logic [AW-1:0]         acc;
  pid_pkg::out_item_t    res;

  logic                  accept;
  logic                  rej_accept;
  logic                  step_accept;
  logic signed [EW:0]    diff;
  logic [EW-1:0]         diff_mag;
  logic                  div_busy;
  logic [NW-1:0]         div_q;
  logic signed [DW-1:0]  d_val;
  logic [DGT-1:0]        digit;
  logic signed [DGT:0]   a17, b17;
  logic signed [PW-1:0]  prod_next;
  logic [SHW-1:0]        prod_sh_next;
  logic                  prod_acc_next;
  logic [AW-1:0]         acc_add;
  logic [SUMW-1:0]       i_sum;
  logic [SUMW-IW:0]      i_hi;
  logic signed [IW-1:0]  i_sat;
  logic [SW-1:0]         sh_acc;
  logic [SW-OW:0]        o_hi;
  logic signed [OW-1:0]  drive_sat;

  assign cfg_ready   = 1'b1;
  assign in_stall    = (state != IDLE);
  assign accept      = in_valid && !in_stall;
  assign rej_accept  = accept && (in_item.elapsed_ticks == '0);
  assign step_accept = accept && (in_item.elapsed_ticks != '0);

  assign diff     = (EW + 1)'(in_item.error_value) - (EW + 1)'(previous_error);
  assign diff_mag = diff[EW] ? EW'(-diff) : diff[EW-1:0];

  pid_div #(
    .NUM_WIDTH(NW),
    .DEN_WIDTH(16)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (step_accept),
    .dividend(NW'(diff_mag) << F),
    .divisor (in_item.elapsed_ticks),
    .busy    (div_busy),
    .quotient(div_q)
  );

  assign d_val = d_neg ? -DW'({1'b0, div_q}) : DW'({1'b0, div_q});
  assign digit = mul_b[DGT * dig +: DGT];

  always_comb begin
    a17           = '0;
    b17           = '0;
    prod_sh_next  = '0;
    prod_acc_next = 1'b0;
    unique case (state)
      MUL_ET: begin
        a17 = (DGT + 1)'(e_q);
        b17 = {1'b0, t_q};
      end
      MUL_P: begin
        a17           = (DGT + 1)'(kp);
        b17           = (DGT + 1)'(e_q);
        prod_sh_next  = SHW'(F);
        prod_acc_next = 1'b1;
      end
      MUL_I: begin
        a17           = (DGT + 1)'(ki);
        b17           = (dig == DGW'(NDI - 1)) ? (DGT + 1)'($signed(digit)) : {1'b0, digit};
        prod_sh_next  = SHW'(DGT * int'(dig) + F);
        prod_acc_next = 1'b1;
      end
      MUL_D: begin
        a17           = (DGT + 1)'(kd);
        b17           = (dig == DGW'(NDD - 1)) ? (DGT + 1)'($signed(digit)) : {1'b0, digit};
        prod_sh_next  = SHW'(DGT * int'(dig));
        prod_acc_next = 1'b1;
      end
      default: begin
        a17 = '0;
      end
    endcase
  end

  assign prod_next = a17 * b17;
  assign acc_add   = AW'(prod) << prod_sh;

  assign i_sum = SUMW'(integral_sum) + SUMW'($signed(prod[32:0]));
  assign i_hi  = i_sum[SUMW-1:IW-1];
  assign i_sat = ((&i_hi) || !(|i_hi)) ? i_sum[IW-1:0]
               : (i_sum[SUMW-1] ? {1'b1, {(IW - 1){1'b0}}} : {1'b0, {(IW - 1){1'b1}}});

  assign sh_acc    = acc[AW-1:2*F];
  assign o_hi      = sh_acc[SW-1:OW-1];
  assign drive_sat = ((&o_hi) || !(|o_hi)) ? sh_acc[OW-1:0]
                   : (sh_acc[SW-1] ? {1'b1, {(OW - 1){1'b0}}} : {1'b0, {(OW - 1){1'b1}}});

  always_ff @(posedge clk) begin
    if (rst) begin
      kp <= pid_pkg::GAIN_RESET;
      ki <= pid_pkg::GAIN_RESET;
      kd <= pid_pkg::GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pid_pkg::CFG_PROPORTIONAL: kp <= cfg_data;
        pid_pkg::CFG_INTEGRAL:     ki <= cfg_data;
        pid_pkg::CFG_DERIVATIVE:   kd <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod    <= prod_next;
    prod_sh <= prod_sh_next;
    if (rst) begin
      state          <= IDLE;
      prod_acc       <= 1'b0;
      out_valid      <= 1'b0;
      integral_sum   <= '0;
      previous_error <= '0;
      held_drive     <= '0;
    end else begin
      prod_acc <= prod_acc_next;
      if (prod_acc) begin
        acc <= acc + acc_add;
      end
      if (out_valid && !out_stall && (state != EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            e_q   <= in_item.error_value;
            t_q   <= in_item.elapsed_ticks;
            d_neg <= diff[EW];
            acc   <= '0;
            if (in_item.elapsed_ticks == '0) begin
              res.drive    <= held_drive;
              res.rejected <= 1'b1;
              state        <= EMIT;
            end else begin
              state <= MUL_ET;
            end
          end
        end
        MUL_ET: begin
          state <= SAT_I;
        end
        SAT_I: begin
          integral_sum <= i_sat;
          mul_b        <= BW'(i_sat);
          state        <= MUL_P;
        end
        MUL_P: begin
          dig   <= '0;
          state <= MUL_I;
        end
        MUL_I: begin
          dig <= dig + 1'b1;
          if (dig == DGW'(NDI - 1)) begin
            state <= WAIT_DIV;
          end
        end
        WAIT_DIV: begin
          if (!div_busy) begin
            mul_b <= BW'(d_val);
            dig   <= '0;
            state <= MUL_D;
          end
        end
        MUL_D: begin
          dig <= dig + 1'b1;
          if (dig == DGW'(NDD - 1)) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          state <= FINISH;
        end
        FINISH: begin
          held_drive     <= drive_sat;
          previous_error <= e_q;
          res.drive      <= drive_sat;
          res.rejected   <= 1'b0;
          state          <= EMIT;
        end
        EMIT: begin
          if (!out_valid || !out_stall) begin
            out_item  <= res;
            out_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  `ASSERT_NEXT(a_reject_keeps_sum, clk, rst, rej_accept, $stable(integral_sum))
  `ASSERT_NEXT(a_reject_keeps_error, clk, rst, rej_accept, $stable(previous_error))
  `ASSERT_NEXT(a_reject_keeps_drive, clk, rst, rej_accept, $stable(held_drive))
  `ASSERT_NEXT(a_step_starts_divider, clk, rst, step_accept, div_busy)
  `ASSERT_IMPLY(a_idle_divider_free, clk, rst, state == IDLE, !div_busy)
  `ASSERT_NEXT(a_emit_holds, clk, rst, (state == EMIT) && out_valid && out_stall, state == EMIT)

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the PID controller step block: predicts each drive item and checks it.
`timescale 1ns / 1ps
module tb_top;

  localparam int FRAC_BITS = 8;
  localparam int INTEGRAL_BITS = 48;
  localparam longint INTEGRAL_MAX = (64'sd1 <<< (INTEGRAL_BITS - 1)) - 64'sd1;
  localparam longint INTEGRAL_MIN = -(64'sd1 <<< (INTEGRAL_BITS - 1));
  localparam logic signed [127:0] DRIVE_MAX = 128'sh7FFF_FFFF;
  localparam logic signed [127:0] DRIVE_MIN = -128'sh8000_0000;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 215;

  typedef enum int {STALL_NONE, STALL_HALF, STALL_RARE, STALL_PERIODIC, STALL_HEAVY} stall_t;

  class drive_scoreboard;
    logic signed [15:0] kp, ki, kd;
    longint integral_acc;
    logic signed [15:0] last_error;
    logic signed [31:0] held_drive;
    pid_pkg::out_item_t expected_q[$];
    int errors;

    function new();
      kp = pid_pkg::GAIN_RESET;
      ki = pid_pkg::GAIN_RESET;
      kd = pid_pkg::GAIN_RESET;
      integral_acc = 0;
      last_error = '0;
      held_drive = '0;
      errors = 0;
    endfunction

    function void set_gain(logic [1:0] index, logic [15:0] value);
      case (index)
        pid_pkg::CFG_PROPORTIONAL: kp = value;
        pid_pkg::CFG_INTEGRAL: ki = value;
        pid_pkg::CFG_DERIVATIVE: kd = value;
        default: ;
      endcase
    endfunction

    function void note_accepted_step(pid_pkg::in_item_t item);
      longint e, t, prev, num, deriv;
      logic signed [127:0] wkp, wki, wkd, we, wint, wd, acc;
      pid_pkg::out_item_t exp_item;
      e = $signed(item.error_value);
      t = item.elapsed_ticks;
      if (t == 0) begin
        exp_item.drive = held_drive;
        exp_item.rejected = 1'b1;
      end else begin
        integral_acc = integral_acc + e * t;
        if (integral_acc > INTEGRAL_MAX) integral_acc = INTEGRAL_MAX;
        if (integral_acc < INTEGRAL_MIN) integral_acc = INTEGRAL_MIN;
        prev = last_error;
        num = (e - prev) * (64'sd1 <<< FRAC_BITS);
        deriv = num / t;
        wkp = kp;
        wki = ki;
        wkd = kd;
        we = e;
        wint = integral_acc;
        wd = deriv;
        acc = ((wkp * we + wki * wint) <<< FRAC_BITS) + wkd * wd;
        acc = acc >>> (2 * FRAC_BITS);
        if (acc > DRIVE_MAX) held_drive = 32'sh7FFF_FFFF;
        else if (acc < DRIVE_MIN) held_drive = 32'sh8000_0000;
        else held_drive = acc[31:0];
        last_error = item.error_value;
        exp_item.drive = held_drive;
        exp_item.rejected = 1'b0;
      end
      expected_q.push_back(exp_item);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_result(pid_pkg::out_item_t got);
      pid_pkg::out_item_t exp_item;
      if (expected_q.size() == 0) begin
        report_mismatch("drive item with no pending step");
      end else begin
        exp_item = expected_q.pop_front();
        if (got.drive !== exp_item.drive)
          report_mismatch($sformatf("drive got %0d expected %0d", got.drive, exp_item.drive));
        if (got.rejected !== exp_item.rejected)
          report_mismatch($sformatf("rejected got %0b expected %0b", got.rejected,
                                    exp_item.rejected));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  pid_pkg::in_item_t in_item;
  logic out_valid;
  logic out_stall;
  pid_pkg::out_item_t out_item;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  drive_scoreboard sb = new();
  logic quiet;
  int hold_left;
  int burst_left;
  int mode_left;
  int idle_cycles;
  stall_t stall_mode;

  pid_controller_step DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (quiet) begin
      out_stall = 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_t'($urandom_range(0, 4));
        mode_left = $urandom_range(20, 150);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE: out_stall = 1'b0;
        STALL_HALF: out_stall = ($urandom_range(0, 1) == 1);
        STALL_RARE: out_stall = ($urandom_range(0, 7) == 0);
        STALL_PERIODIC: out_stall = (mode_left % 3 == 0);
        default: out_stall = ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_item);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("FAIL pid_controller_step");
      $finish;
    end
  end

  task automatic send_item(input pid_pkg::in_item_t item);
    int gap;
    in_item = item;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_accepted_step(item);
    @(negedge clk);
    if (!quiet) begin
      if (burst_left == 0) begin
        in_valid = 1'b0;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6);
        repeat (gap) @(negedge clk);
        burst_left = $urandom_range(0, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic step(input logic signed [15:0] err, input logic [15:0] ticks);
    pid_pkg::in_item_t item;
    item.error_value = err;
    item.elapsed_ticks = ticks;
    send_item(item);
  endtask

  task automatic write_gain(input logic [1:0] index, input logic [15:0] value);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_gain(index, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_gains(input logic [15:0] p_gain, input logic [15:0] i_gain,
                            input logic [15:0] d_gain);
    settle();
    write_gain(pid_pkg::CFG_PROPORTIONAL, p_gain);
    write_gain(pid_pkg::CFG_INTEGRAL, i_gain);
    write_gain(pid_pkg::CFG_DERIVATIVE, d_gain);
    if ($urandom_range(0, 1) == 1) write_gain(CFG_UNUSED, 16'($urandom));
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3, 4, 5: return 16'($urandom_range(0, 1024)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic pid_pkg::in_item_t random_step();
    pid_pkg::in_item_t item;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) item.elapsed_ticks = '0;
    else if (sel < 45) item.elapsed_ticks = 16'($urandom_range(1, 8));
    else if (sel < 55) item.elapsed_ticks = 16'hFFFF;
    else item.elapsed_ticks = 16'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 10) item.error_value = ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
    else if (sel < 40) item.error_value = 16'($urandom_range(0, 400)) - 16'd200;
    else item.error_value = 16'($urandom);
    return item;
  endfunction

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = pid_pkg::CFG_PROPORTIONAL;
    cfg_data = '0;
    quiet = 1'b0;
    hold_left = 0;
    burst_left = 0;
    mode_left = 0;
    idle_cycles = 0;
    stall_mode = STALL_NONE;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    step(0, 0);
    step(32767, 1);
    step(-32768, 1);
    step(0, 0);
    step(-32768, 65535);
    step(32767, 65535);
    step(1, 65535);
    step(-1, 3);
    step(5, 3);
    step(0, 1);

    load_gains(16'h7FFF, 16'h7FFF, 16'h7FFF);
    write_gain(CFG_UNUSED, 16'h1234);
    repeat (3) step(32767, 65535);
    step(0, 0);
    repeat (6) step(-32768, 65535);

    load_gains(16'h8000, 16'h8000, 16'h8000);
    step(32767, 1);
    step(-32768, 1);
    step(100, 2);

    load_gains(16'h0000, 16'h0000, 16'h0000);
    step(1234, 5);
    step(0, 0);

    load_gains(16'h7FFF, 16'h0000, 16'h8000);
    step(-32768, 1);
    step(32767, 1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_gains(pick_gain(), pick_gain(), pick_gain());
      quiet = (p == 2);
      if (p == 0 || p == 4) hold_left = HOLD_CYCLES;
      repeat (ITEMS_PER_PHASE) send_item(random_step());
    end
    quiet = 1'b0;

    settle();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS pid_controller_step");
    end else begin
      $display("FAIL pid_controller_step");
    end
    $finish;
  end
endmodule
